// ===== design/pcm_pkg.sv =====
// Shared types, constants and saturating helpers for the playback clock mapper.
// Used by pcm_scale, pcm_dp, pcm_ctrl and playback_clock_mapper. No dependencies.
`default_nettype none

package pcm_pkg;

  localparam int RATE_FRAC_BITS = 16;
  localparam logic [63:0] US_SCALE   = 64'd1000 << RATE_FRAC_BITS;
  localparam logic [23:0] RATE_ONE   = 24'd1 << RATE_FRAC_BITS;
  localparam logic [63:0] LIM_WIDE   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_NARROW = 64'h0000_0000_7FFF_FFFF;

  localparam logic [2:0] KIND_HARD  = 3'd0;
  localparam logic [2:0] KIND_SOFT  = 3'd1;
  localparam logic [2:0] KIND_RATE  = 3'd2;
  localparam logic [2:0] KIND_PAUSE = 3'd3;
  localparam logic [2:0] KIND_POSQ  = 3'd4;
  localparam logic [2:0] KIND_TIMEQ = 3'd5;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_HARD,
    OP_S_SRC,
    OP_C_TMP,
    OP_K1_ANCHOR,
    OP_MK_CHECK,
    OP_S_DSTP,
    OP_C_DSTP,
    OP_S_SRATE,
    OP_C_SRATE,
    OP_ADV_PAUSED,
    OP_S_ADV,
    OP_C_ADV,
    OP_SET_RATE,
    OP_MK_SETUP2,
    OP_SET_PAUSE,
    OP_S_QPOS,
    OP_C_QPOS,
    OP_S_QTIME,
    OP_C_QTIME,
    OP_OUT_LOAD
  } op_e;

  typedef struct packed {
    op_e op;
  } pcm_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       fix_zero;
    logic       rate_chg;
    logic       pause_chg;
    logic       paused;
    logic       slew_valid;
    logic       span_pos;
    logic       sc_done;
    logic       out_free;
  } pcm_sts_t;

  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : LIM_WIDE;
    end
    return s;
  endfunction

  function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : LIM_WIDE;
    end
    return s;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

endpackage

`default_nettype wire

// ===== design/pcm_scale.sv =====
// Shared multiply-divide unit: trunc0(a * m / d) with saturation to a limit.
// 64x32 product in two partial products, then restoring division, one bit a cycle.
// Depends on pcm_pkg.
`default_nettype none

module pcm_scale import pcm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic        m_neg_i,
  input  wire logic [31:0] m_mag_i,
  input  wire logic [63:0] d_i,
  input  wire logic [63:0] lim_i,
  output logic             done_o,
  output logic [63:0]      res_o
);

  localparam logic [2:0] SC_IDLE = 3'd0;
  localparam logic [2:0] SC_MUL0 = 3'd1;
  localparam logic [2:0] SC_MUL1 = 3'd2;
  localparam logic [2:0] SC_SUM  = 3'd3;
  localparam logic [2:0] SC_DIV  = 3'd4;
  localparam logic [2:0] SC_FIN  = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [63:0] x_q, d_q, lim_q, plo_q, phi_q, rem_q, res_q;
  logic [31:0] y_q;
  logic        neg_q;
  logic [95:0] dvd_q;

  logic [64:0] rem_sh, rem_sub;
  logic        ge;
  logic [63:0] cap, qsat;
  logic        over;

  assign rem_sh  = {rem_q, dvd_q[95]};
  assign rem_sub = rem_sh - {1'b0, d_q};
  assign ge      = rem_sh >= {1'b0, d_q};
  assign cap     = lim_q + {63'd0, neg_q};
  assign over    = (|dvd_q[95:64]) || (dvd_q[63:0] > cap);
  assign qsat    = over ? cap : dvd_q[63:0];

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    unique case (st_q)
      SC_IDLE: if (start_i) st_d = SC_MUL0;
      SC_MUL0: st_d = SC_MUL1;
      SC_MUL1: st_d = SC_SUM;
      SC_SUM: begin
        st_d  = SC_DIV;
        cnt_d = 7'd0;
      end
      SC_DIV: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd95) st_d = SC_FIN;
      end
      SC_FIN: begin
        done_d = 1'b1;
        st_d   = SC_IDLE;
      end
      default: st_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SC_IDLE;
      cnt_q  <= 7'd0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SC_IDLE && start_i) begin
      x_q   <= mag64(a_i);
      y_q   <= m_mag_i;
      neg_q <= a_i[63] ^ m_neg_i;
      d_q   <= d_i;
      lim_q <= lim_i;
    end
    if (st_q == SC_MUL0) plo_q <= 64'(x_q[31:0] * y_q);
    if (st_q == SC_MUL1) phi_q <= 64'(x_q[63:32] * y_q);
    if (st_q == SC_SUM) begin
      dvd_q <= {32'd0, plo_q} + {phi_q, 32'd0};
      rem_q <= 64'd0;
    end
    if (st_q == SC_DIV) begin
      rem_q <= ge ? rem_sub[63:0] : rem_sh[63:0];
      dvd_q <= {dvd_q[94:0], ge};
    end
    if (st_q == SC_FIN) res_q <= neg_q ? (64'd0 - qsat) : qsat;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== design/pcm_dp.sv =====
// Datapath: input latch, clock state, slew window, operand selection, output register.
// Executes one command a cycle from pcm_ctrl. Depends on pcm_pkg and pcm_scale.
`default_nettype none

module pcm_dp import pcm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire pcm_cmd_t     cmd_i,
  output pcm_sts_t          sts_o,
  input  wire logic [279:0] in_data_i,
  input  wire logic [2:0]   in_kind_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [135:0]      out_data_o
);

  // request latch
  logic [2:0]  kind_q;
  logic [63:0] now_q, tp_q, pos_q, fix_q;
  logic [23:0] rate_in_q;
  logic        pflag_q, ign_q;

  // clock state
  logic [63:0] anc_p_q, anc_t_q;
  logic [23:0] play_rate_q;
  logic        paused_q, slew_valid_q;
  logic [63:0] src_t_q, src_p_q, dst_t_q, dst_p_q;
  logic [31:0] srate_q;

  // working registers
  logic [63:0] mk_src_q, mk_sp_q, mk_dst_q, span_q, base_q, tmp_q;
  logic [63:0] pos_out_q, time_out_q;
  logic        out_valid_q;
  logic [135:0] out_data_q;

  logic        sc_start, sc_done;
  logic [63:0] sc_a, sc_d, sc_lim, sc_res, base_d;
  logic        sc_m_neg;
  logic [31:0] sc_m_mag;
  logic [63:0] span, sum, tpv, posv, dd;
  logic        in_win;
  logic [32:0] rsel, rneg;

  assign span = ssub(mk_dst_q, mk_src_q);
  assign sum  = sadd(base_q, sc_res);
  assign dd   = ssub(now_q, anc_t_q);

  assign sc_start = (cmd_i.op == OP_S_SRC) || (cmd_i.op == OP_S_QPOS) ||
                    (cmd_i.op == OP_S_QTIME) || (cmd_i.op == OP_S_ADV) ||
                    (cmd_i.op == OP_S_DSTP) || (cmd_i.op == OP_S_SRATE);

  always_comb begin
    tpv  = (cmd_i.op == OP_S_QPOS) ? ((paused_q && !ign_q) ? anc_t_q : tp_q) : now_q;
    posv = (paused_q && !ign_q) ? anc_p_q : pos_q;
    in_win = 1'b0;
    rsel   = {9'd0, play_rate_q};
    sc_a     = ssub(now_q, anc_t_q);
    base_d   = anc_p_q;
    sc_d     = US_SCALE;
    sc_lim   = LIM_WIDE;
    unique case (cmd_i.op)
      OP_S_SRC, OP_S_QPOS: begin
        in_win = slew_valid_q && ($signed(tpv) < $signed(dst_t_q));
        if (in_win) begin
          if ($signed(tpv) > $signed(src_t_q)) rsel = {srate_q[31], srate_q};
          sc_a   = ssub(tpv, src_t_q);
          base_d = src_p_q;
        end else begin
          sc_a = ssub(tpv, anc_t_q);
        end
      end
      OP_S_DSTP: sc_a = ssub(mk_dst_q, anc_t_q);
      OP_S_SRATE: begin
        sc_a   = ssub(dst_p_q, src_p_q);
        rsel   = US_SCALE[32:0];
        sc_d   = span_q;
        sc_lim = LIM_NARROW;
      end
      OP_S_QTIME: begin
        in_win = slew_valid_q && ($signed(posv) < $signed(dst_p_q));
        if (in_win && $signed(posv) > $signed(src_p_q)) begin
          sc_d = {{32{srate_q[31]}}, srate_q};
        end else begin
          sc_d = {40'd0, play_rate_q};
        end
        // non-positive divisor rate falls back to the smallest positive one
        if (sc_d[63] || sc_d == 64'd0) sc_d = 64'd1;
        rsel = US_SCALE[32:0];
        if (in_win) begin
          sc_a   = ssub(posv, src_p_q);
          base_d = src_t_q;
        end else begin
          sc_a   = ssub(posv, anc_p_q);
          base_d = anc_t_q;
        end
      end
      default: ;
    endcase
    rneg     = 33'd0 - rsel;
    sc_m_neg = rsel[32];
    sc_m_mag = rsel[32] ? rneg[31:0] : rsel[31:0];
  end

  pcm_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sc_start),
    .a_i     (sc_a),
    .m_neg_i (sc_m_neg),
    .m_mag_i (sc_m_mag),
    .d_i     (sc_d),
    .lim_i   (sc_lim),
    .done_o  (sc_done),
    .res_o   (sc_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anc_p_q      <= 64'd0;
      anc_t_q      <= 64'd0;
      play_rate_q  <= RATE_ONE;
      paused_q     <= 1'b0;
      slew_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.op == OP_OUT_LOAD) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_HARD: begin
          slew_valid_q <= 1'b0;
          anc_p_q      <= pos_q;
          anc_t_q      <= tp_q;
        end
        OP_K1_ANCHOR: begin
          anc_p_q <= pos_q;
          anc_t_q <= tp_q;
        end
        OP_MK_CHECK: if (!(!span[63] && span != 64'd0)) slew_valid_q <= 1'b0;
        OP_C_SRATE: slew_valid_q <= 1'b1;
        OP_ADV_PAUSED: anc_t_q <= now_q;
        OP_C_ADV: begin
          anc_p_q <= sum;
          anc_t_q <= now_q;
          if (slew_valid_q && $signed(dst_t_q) <= $signed(now_q)) slew_valid_q <= 1'b0;
        end
        OP_SET_RATE: play_rate_q <= rate_in_q;
        OP_SET_PAUSE: paused_q <= pflag_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (sc_start) base_q <= base_d;
    unique case (cmd_i.op)
      OP_LATCH: begin
        kind_q     <= in_kind_i;
        now_q      <= {1'b0, in_data_i[62:0]};
        tp_q       <= {1'b0, in_data_i[125:63]};
        pos_q      <= in_data_i[189:126];
        fix_q      <= {1'b0, in_data_i[252:190]};
        rate_in_q  <= in_data_i[276:253];
        pflag_q    <= in_data_i[277];
        ign_q      <= in_data_i[278];
        pos_out_q  <= 64'd0;
        time_out_q <= 64'd0;
      end
      OP_C_TMP: tmp_q <= sum;
      OP_K1_ANCHOR: begin
        mk_src_q <= now_q;
        mk_sp_q  <= tmp_q;
        mk_dst_q <= sadd(now_q, fix_q);
      end
      OP_MK_CHECK: if (!span[63] && span != 64'd0) begin
        src_t_q <= mk_src_q;
        src_p_q <= mk_sp_q;
        dst_t_q <= mk_dst_q;
        span_q  <= span;
      end
      OP_C_DSTP: dst_p_q <= sum;
      OP_C_SRATE: srate_q <= sc_res[31:0];
      OP_ADV_PAUSED: if (slew_valid_q) begin
        // paused: the window slides along with the clock
        dst_t_q <= sadd(dst_t_q, dd);
        src_t_q <= sadd(src_t_q, dd);
      end
      OP_MK_SETUP2: begin
        mk_src_q <= anc_t_q;
        mk_sp_q  <= anc_p_q;
        mk_dst_q <= dst_t_q;
      end
      OP_C_QPOS: pos_out_q <= sum;
      OP_C_QTIME: time_out_q <= sum;
      OP_OUT_LOAD: out_data_q <= {7'd0, slew_valid_q, time_out_q, pos_out_q};
      default: ;
    endcase
  end

  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.fix_zero   = (fix_q == 64'd0);
    sts_o.rate_chg   = (rate_in_q != 24'd0) && (rate_in_q != play_rate_q);
    sts_o.pause_chg  = (pflag_q != paused_q);
    sts_o.paused     = paused_q;
    sts_o.slew_valid = slew_valid_q;
    sts_o.span_pos   = !span[63] && (span != 64'd0);
    sts_o.sc_done    = sc_done;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== design/pcm_ctrl.sv =====
// Controller: sequences each request through the datapath's commands.
// Depends on pcm_pkg; talks to pcm_dp by pcm_cmd_t / pcm_sts_t only.
`default_nettype none

module pcm_ctrl import pcm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire pcm_sts_t sts_i,
  output pcm_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_W_SRC   = 4'd2;
  localparam logic [3:0] S_K1A     = 4'd3;
  localparam logic [3:0] S_MK_CHK  = 4'd4;
  localparam logic [3:0] S_DSTP    = 4'd5;
  localparam logic [3:0] S_W_DSTP  = 4'd6;
  localparam logic [3:0] S_SRATE   = 4'd7;
  localparam logic [3:0] S_W_SRATE = 4'd8;
  localparam logic [3:0] S_ADV     = 4'd9;
  localparam logic [3:0] S_W_ADV   = 4'd10;
  localparam logic [3:0] S_POST    = 4'd11;
  localparam logic [3:0] S_MK2     = 4'd12;
  localparam logic [3:0] S_W_Q     = 4'd13;
  localparam logic [3:0] S_FIN     = 4'd14;

  logic [3:0] st_q, st_d;

  always_comb begin
    st_d       = st_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = (st_q == S_IDLE);
    unique case (st_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.op = OP_LATCH;
        st_d     = S_DISP;
      end
      S_DISP: begin
        priority if (sts_i.kind == KIND_HARD ||
                     (sts_i.kind == KIND_SOFT && sts_i.fix_zero)) begin
          cmd_o.op = OP_HARD;
          st_d     = S_FIN;
        end else if (sts_i.kind == KIND_SOFT) begin
          cmd_o.op = OP_S_SRC;
          st_d     = S_W_SRC;
        end else if (sts_i.kind == KIND_RATE) begin
          st_d = sts_i.rate_chg ? S_ADV : S_FIN;
        end else if (sts_i.kind == KIND_PAUSE) begin
          st_d = sts_i.pause_chg ? S_ADV : S_FIN;
        end else if (sts_i.kind == KIND_POSQ) begin
          cmd_o.op = OP_S_QPOS;
          st_d     = S_W_Q;
        end else if (sts_i.kind == KIND_TIMEQ) begin
          cmd_o.op = OP_S_QTIME;
          st_d     = S_W_Q;
        end else begin
          st_d = S_FIN;
        end
      end
      S_W_SRC: if (sts_i.sc_done) begin
        cmd_o.op = OP_C_TMP;
        st_d     = S_K1A;
      end
      S_K1A: begin
        cmd_o.op = OP_K1_ANCHOR;
        st_d     = S_MK_CHK;
      end
      S_MK_CHK: begin
        cmd_o.op = OP_MK_CHECK;
        st_d     = sts_i.span_pos ? S_DSTP : S_FIN;
      end
      S_DSTP: begin
        cmd_o.op = OP_S_DSTP;
        st_d     = S_W_DSTP;
      end
      S_W_DSTP: if (sts_i.sc_done) begin
        cmd_o.op = OP_C_DSTP;
        st_d     = S_SRATE;
      end
      S_SRATE: begin
        cmd_o.op = OP_S_SRATE;
        st_d     = S_W_SRATE;
      end
      S_W_SRATE: if (sts_i.sc_done) begin
        cmd_o.op = OP_C_SRATE;
        st_d     = S_FIN;
      end
      S_ADV: begin
        if (sts_i.paused) begin
          cmd_o.op = OP_ADV_PAUSED;
          st_d     = S_POST;
        end else begin
          cmd_o.op = OP_S_ADV;
          st_d     = S_W_ADV;
        end
      end
      S_W_ADV: if (sts_i.sc_done) begin
        cmd_o.op = OP_C_ADV;
        st_d     = S_POST;
      end
      S_POST: begin
        if (sts_i.kind == KIND_RATE) begin
          cmd_o.op = OP_SET_RATE;
          st_d     = sts_i.slew_valid ? S_MK2 : S_FIN;
        end else begin
          cmd_o.op = OP_SET_PAUSE;
          st_d     = S_FIN;
        end
      end
      S_MK2: begin
        cmd_o.op = OP_MK_SETUP2;
        st_d     = S_MK_CHK;
      end
      S_W_Q: if (sts_i.sc_done) begin
        cmd_o.op = (sts_i.kind == KIND_POSQ) ? OP_C_QPOS : OP_C_QTIME;
        st_d     = S_FIN;
      end
      S_FIN: if (sts_i.out_free) begin
        cmd_o.op = OP_OUT_LOAD;
        st_d     = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/playback_clock_mapper.sv =====
// Top level of the playback clock mapper: controller plus datapath.
// Depends on pcm_pkg, pcm_ctrl, pcm_dp (and pcm_scale through pcm_dp).
//
//  port group | dir | carries
//  s_axis     | in  | one event request (kind in tuser, operands in tdata)
//  m_axis     | out | one result per request (query answers, window flag)
//
// Hard sync, ignored changes and unknown kinds need no multiply-divide pass, and a change
// while paused advances the anchor without one. Each pass computes one quotient bit a
// cycle over a 96-bit product; queries and unpaused changes take one pass,
// a soft sync or a rate change with an open window up to three.
// A new request is taken once the previous one has been handed to the output
// register, even while that result still waits. Reset is asynchronous.
`default_nettype none

module playback_clock_mapper import pcm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // now_ns[62:0], time_point_ns[125:63], track_pos_us[189:126],
  // fixing_ns[252:190], new_rate[276:253], pause_flag[277], ignore_pause[278]
  input  wire logic [279:0] s_axis_tdata,
  // kind[2:0]
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // position_us[63:0], time_ns[127:64], soft_active[128]
  output logic [135:0]      m_axis_tdata
);

  pcm_cmd_t cmd;
  pcm_sts_t sts;

  pcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while previous one still in work");

  a_done_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.sc_done |-> !s_axis_tready)
    else $error("divider finished with controller idle");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_OUT_LOAD) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending one");

endmodule

`default_nettype wire
